FILE: hdl/differential_drive_odometry_macros.svh
// Assertion macros shared by the odometry checker
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH

// same-cycle implication
`define DDO_ASSERT_NOW(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("odometry check failed");

// next-cycle implication
`define DDO_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("odometry check failed");

`endif

FILE: hdl/ddo_pkg.sv
// Types, constants and the arctangent table for the odometry block
`timescale 1ns / 1ps

package ddo_pkg;

	localparam int unsigned DW = 34;  // CORDIC and multiplier operand width
	localparam int unsigned PW = 68;  // product width
	localparam int unsigned CNT_W = 5;  // index into the 32-entry arctangent table

	localparam logic signed [DW-1:0] CORDIC_X0 = 34'sh026DD3B6A;
	localparam logic signed [DW-1:0] HALF_PI_BA = 34'sh040000000;
	localparam logic signed [DW-1:0] PI_BA = 34'sh080000000;

	localparam logic [1:0] REG_DIST_PER_TICK = 2'd0;
	localparam logic [1:0] REG_HEADING_PER_TICK_DIFF = 2'd1;
	localparam logic [1:0] REG_INV_WHEEL_BASE = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DELTA,
		ST_MHEAD,
		ST_MDL,
		ST_MDR,
		ST_MANG,
		ST_ROT,
		ST_MX,
		ST_MY,
		ST_UY,
		ST_FIN
	} ddo_state_t;

	// atan(2^-i) in binary angle units, 2^32 per turn
	function automatic logic [31:0] atan_ba(input logic [CNT_W-1:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/differential_drive_odometry.sv
// Differential-drive odometry: wheel counts in, pose out (saturating Q16.16 x and y)
`timescale 1ns / 1ps

// One item is handled at a time. After a word is accepted the block drops
// s_tready until its result is loaded into the output register; a word with
// the reset flag set clears the pose and skips the arithmetic. The sequencer
// runs each item through one shared 34x34 signed multiplier (six products
// per item) and one CORDIC rotation stage that runs CORDIC_STEPS times.
// The result sits in an output register, so a new word is accepted while
// the previous result still waits; the block only holds in its last step
// if that register has not been drained. Registers live on the APB port at
// 0x0 (dist_per_tick), 0x4 (heading_per_tick_diff) and 0x8
// (inv_wheel_base); write them only while the block is idle.
module differential_drive_odometry
	import ddo_pkg::*;
#(
	parameter int CORDIC_STEPS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	// APB configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// left_ticks[31:0], right_ticks[63:32], left_wheel_speed[87:64],
	// right_wheel_speed[111:88]
	input  logic [111:0] s_tdata,
	// reset_pose[0]
	input  logic         s_tuser,
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// x_pos[31:0], y_pos[63:32], heading[95:64], linear_vel[119:96],
	// angular_vel[143:120]
	output logic [143:0] m_tdata
);

	localparam logic [CNT_W-1:0] ROT_LAST = CNT_W'(CORDIC_STEPS - 1);

	ddo_state_t state_q, state_d;

	// configuration
	logic [31:0] dist_per_tick_q;
	logic [31:0] heading_per_tick_diff_q;
	logic [23:0] inv_wheel_base_q;

	// odometry state
	logic [31:0] last_left_q, last_right_q;
	logic [31:0] pose_x_q, pose_y_q, pose_heading_q;

	// item and datapath registers
	logic [31:0] lt_q, rt_q;
	logic        rp_q;
	logic [24:0] wdiff_q;
	logic [23:0] lin_q, ang_q;
	logic [31:0] dl_q, dr_q;
	logic [51:0] acc_q;
	logic [31:0] c_q;
	logic signed [DW-1:0] x_q, y_q, z_q;
	logic        flip_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [PW-1:0] p_q;

	// output register
	logic         m_tvalid_q;
	logic [31:0]  out_x_q, out_y_q, out_head_q;
	logic [23:0]  out_lin_q, out_ang_q;

	logic s_acc, cfg_wr, out_free, out_load, mul_en, rot_done;
	logic signed [DW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] mul_p;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[3:2])
			REG_DIST_PER_TICK: prdata = dist_per_tick_q;
			REG_HEADING_PER_TICK_DIFF: prdata = heading_per_tick_diff_q;
			REG_INV_WHEEL_BASE: prdata = {8'd0, inv_wheel_base_q};
			default: prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_per_tick_q <= 32'd858993;
			heading_per_tick_diff_q <= 32'd683565;
			inv_wheel_base_q <= 24'd327680;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_DIST_PER_TICK: dist_per_tick_q <= pwdata;
				REG_HEADING_PER_TICK_DIFF: heading_per_tick_diff_q <= pwdata;
				REG_INV_WHEEL_BASE: inv_wheel_base_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// ---------------- sequencer ----------------
	assign out_free = !m_tvalid_q || m_tready;
	assign rot_done = (cnt_q == ROT_LAST);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_DELTA;
			ST_DELTA: state_d = rp_q ? ST_FIN : ST_MHEAD;
			ST_MHEAD: state_d = ST_MDL;
			ST_MDL: state_d = ST_MDR;
			ST_MDR: state_d = ST_MANG;
			ST_MANG: state_d = ST_ROT;
			ST_ROT: if (rot_done) state_d = ST_MX;
			ST_MX: state_d = ST_MY;
			ST_MY: state_d = ST_UY;
			ST_UY: state_d = ST_FIN;
			ST_FIN: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		out_load = (state_q == ST_FIN) && out_free;
		case (state_q)
			ST_MHEAD, ST_MDL, ST_MDR, ST_MANG, ST_MX, ST_MY: mul_en = 1'b1;
			default: mul_en = 1'b0;
		endcase
	end

	assign s_acc = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// ---------------- shared multiplier ----------------
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MHEAD: begin
				mul_a = DW'(signed'(dr_q - dl_q));
				mul_b = {2'b00, heading_per_tick_diff_q};
			end
			ST_MDL: begin
				mul_a = DW'(signed'(dl_q));
				mul_b = {2'b00, dist_per_tick_q};
			end
			ST_MDR: begin
				mul_a = DW'(signed'(dr_q));
				mul_b = {2'b00, dist_per_tick_q};
			end
			ST_MANG: begin
				mul_a = DW'(signed'(wdiff_q));
				mul_b = {10'd0, inv_wheel_base_q};
			end
			ST_MX: begin
				mul_a = DW'(signed'(c_q));
				mul_b = flip_q ? -x_q : x_q;
			end
			ST_MY: begin
				mul_a = DW'(signed'(c_q));
				mul_b = flip_q ? -y_q : y_q;
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (mul_en) p_q <= mul_p;
	end

	// ---------------- datapath helpers ----------------
	logic [24:0] spd_sum;
	logic [52:0] c_sum;
	logic [51:0] c_half;
	logic [31:0] c_sat;
	logic [23:0] ang_sat;
	logic signed [DW-1:0] hz, z_init;
	logic        flip_init;
	logic signed [DW-1:0] xs, ys, at;
	logic [38:0] pos_sum;
	logic [31:0] pos_sat;
	logic [31:0] pos_base;

	assign spd_sum = {s_tdata[87], s_tdata[87:64]} + {s_tdata[111], s_tdata[111:88]};

	// center distance: floor((dl*k>>16 + dr*k>>16) / 2), saturated to 32 bits
	assign c_sum = {acc_q[51], acc_q} + {p_q[PW-1], p_q[PW-1:16]};
	assign c_half = c_sum[52:1];
	always_comb begin
		if (c_half[51:31] == {21{c_half[51]}}) c_sat = c_half[31:0];
		else c_sat = c_half[51] ? 32'h80000000 : 32'h7FFFFFFF;
	end

	always_comb begin
		if (p_q[PW-1:39] == {29{p_q[PW-1]}}) ang_sat = p_q[39:16];
		else ang_sat = p_q[PW-1] ? 24'h800000 : 24'h7FFFFF;
	end

	// fold the heading into [-pi/2, pi/2]
	assign hz = DW'(signed'(pose_heading_q));
	always_comb begin
		z_init = hz;
		flip_init = 1'b0;
		if (hz > HALF_PI_BA) begin
			z_init = hz - PI_BA;
			flip_init = 1'b1;
		end else if (hz < -HALF_PI_BA) begin
			z_init = hz + PI_BA;
			flip_init = 1'b1;
		end
	end

	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign at = DW'(atan_ba(cnt_q));

	// pose update: pose + floor(p / 2^30), saturated
	assign pos_base = (state_q == ST_MY) ? pose_x_q : pose_y_q;
	assign pos_sum = {{7{pos_base[31]}}, pos_base} + {p_q[PW-1], p_q[PW-1:30]};
	always_comb begin
		if (pos_sum[38:31] == {8{pos_sum[38]}}) pos_sat = pos_sum[31:0];
		else pos_sat = pos_sum[38] ? 32'h80000000 : 32'h7FFFFFFF;
	end

	// ---------------- odometry state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_left_q <= '0;
			last_right_q <= '0;
			pose_x_q <= '0;
			pose_y_q <= '0;
			pose_heading_q <= '0;
		end else begin
			case (state_q)
				ST_DELTA: begin
					last_left_q <= rp_q ? 32'd0 : lt_q;
					last_right_q <= rp_q ? 32'd0 : rt_q;
					if (rp_q) begin
						pose_x_q <= '0;
						pose_y_q <= '0;
						pose_heading_q <= '0;
					end
				end
				ST_MDL: pose_heading_q <= pose_heading_q + p_q[31:0];
				ST_MY: pose_x_q <= pos_sat;
				ST_UY: pose_y_q <= pos_sat;
				default: ;
			endcase
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (s_acc) begin
			lt_q <= s_tdata[31:0];
			rt_q <= s_tdata[63:32];
			rp_q <= s_tuser;
			lin_q <= spd_sum[24:1];
			wdiff_q <= {s_tdata[111], s_tdata[111:88]} - {s_tdata[87], s_tdata[87:64]};
		end
		case (state_q)
			ST_DELTA: begin
				dl_q <= lt_q - last_left_q;
				dr_q <= rt_q - last_right_q;
				if (rp_q) begin
					lin_q <= '0;
					ang_q <= '0;
				end
			end
			ST_MDR: acc_q <= p_q[PW-1:16];
			ST_MANG: begin
				c_q <= c_sat;
				x_q <= CORDIC_X0;
				y_q <= '0;
				z_q <= z_init;
				flip_q <= flip_init;
				cnt_q <= '0;
			end
			ST_ROT: begin
				// product register still holds the yaw-rate term here
				if (cnt_q == '0) ang_q <= ang_sat;
				if (z_q >= 0) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end
				cnt_q <= cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid_q <= 1'b0;
		else if (out_load) m_tvalid_q <= 1'b1;
		else if (m_tready) m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q <= pose_x_q;
			out_y_q <= pose_y_q;
			out_head_q <= pose_heading_q;
			out_lin_q <= lin_q;
			out_ang_q <= ang_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {out_ang_q, out_lin_q, out_head_q, out_y_q, out_x_q};

endmodule

FILE: hdl/ddo_checker.sv
// Port-level checks for the odometry block, bound to its top level
`timescale 1ns / 1ps

`include "differential_drive_odometry_macros.svh"

module ddo_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [143:0] m_tdata
);

	// a result word waiting on the sink holds still
	`DDO_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// after taking a word the block stays busy through its delta step and the step that follows
	`DDO_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready ##1 !s_tready)

	// a new result only shows up at the end of an item's work
	`DDO_ASSERT_NOW(a_result_from_work, clk, arst_n, $rose(m_tvalid), $past(!s_tready))

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
